>>> rtl/core/ftsr_pkg.sv
`timescale 1ns / 1ps

package ftsr_pkg;

   // Coordinate format and screen limits
   localparam int COORD_FRAC_BITS = 4;
   localparam int MAX_SCREEN      = 2048;
   localparam int ONE_PX          = 1 << COORD_FRAC_BITS;
   localparam int Q16_SHIFT       = 16 - COORD_FRAC_BITS;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Register indexes (address bit 2)
   localparam int  CSR_AW            = 3;
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   // Command queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

   // Divider
   localparam int DIV_W  = 48;
   localparam int DIV_CW = $clog2(DIV_W);

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] v0_x;
      logic signed [15:0] v0_y;
      logic signed [15:0] v1_x;
      logic signed [15:0] v1_y;
      logic signed [15:0] v2_x;
      logic signed [15:0] v2_y;
      logic        [31:0] color;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } q_head_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] numer;
      logic        [16:0]      denom;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic [11:0] width;
      logic [11:0] height;
   } limit_type;

   typedef struct packed {
      logic [10:0] y;
      logic [11:0] x_start;
      logic [11:0] x_end;
      logic [31:0] color;
      logic        empty;
      logic        last;
   } span_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOWER,
      PH_UPPER
   } phase_type;

   typedef enum logic [4:0] {
      ST_FETCH,
      ST_LDIV,
      ST_LO_CHK,
      ST_LO_DIV,
      ST_LO_M1,
      ST_LO_M2,
      ST_LO_CMP,
      ST_UP_CHK,
      ST_UP_DIV,
      ST_UP_M1,
      ST_UP_M2,
      ST_UP_M3,
      ST_UP_M4,
      ST_UP_PDIV,
      ST_ROWS,
      ST_SK1,
      ST_SK2,
      ST_SK3,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/core/ftsr_cmd_queue.sv
`timescale 1ns / 1ps

module ftsr_cmd_queue import ftsr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_item_type in_item,
   output logic         in_ready,
   output q_head_type   head,
   input  logic         pop
);

   req_item_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_PW-1:0]   wr_ff, wr_in;
   logic [FIFO_PW-1:0]   rd_ff, rd_in;
   logic [FIFO_PW:0]     count_ff, count_in;
   logic                 push;
   logic                 take;

   assign in_ready   = (count_ff != (FIFO_PW+1)'(FIFO_DEPTH));
   assign push       = in_valid && in_ready;
   assign take       = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = take ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

>>> rtl/core/ftsr_divider.sv
`timescale 1ns / 1ps

// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
module ftsr_divider import ftsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CW-1:0]       cnt_ff;
   logic [DIV_W-1:0]        num_ff, num_in;
   logic [16:0]             rem_ff, rem_in;
   logic [16:0]             den_ff;
   logic                    neg_ff;
   logic signed [DIV_W-1:0] quot_ff;
   logic [DIV_W-1:0]        mag;
   logic [17:0]             rem_sh;
   logic                    ge;
   logic                    last;

   assign mag    = req.numer[DIV_W-1] ? DIV_W'(-req.numer) : DIV_W'(req.numer);
   assign rem_sh = {rem_ff, num_ff[DIV_W-1]};
   assign ge     = (rem_sh >= {1'b0, den_ff});
   assign last   = (cnt_ff == DIV_CW'(DIV_W-1));

   // one restoring step
   always_comb begin
      rem_in = ge ? 17'(rem_sh - {1'b0, den_ff}) : 17'(rem_sh);
      num_in = {num_ff[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= mag;
         rem_ff <= '0;
         den_ff <= req.denom;
         neg_ff <= req.numer[DIV_W-1];
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         if (last) begin
            quot_ff <= neg_ff ? $signed(-num_in) : $signed(num_in);
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

>>> rtl/core/ftsr_engine.sv
`timescale 1ns / 1ps

// Back end: triangle setup sequencer and span stepper.
module ftsr_engine import ftsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  q_head_type  head,
   output logic        head_pop,
   input  limit_type   lim,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        span_valid,
   output span_type    span,
   input  logic        span_ready
);

   state_type          state_ff, state_in;
   phase_type          phase_ff;
   logic signed [15:0] mnx_ff, mny_ff, mdx_ff, mdy_ff, mxx_ff, mxy_ff;
   logic signed [31:0] long_slope_ff, short_slope_ff, left_ff, right_ff;
   logic [11:0]        cur_row_ff, end_row_ff, skip_ff;
   logic [31:0]        color_ff;
   logic               long_right_ff, half_up_ff, from_tick_ff;
   logic signed [50:0] prod_ff, p1_ff;
   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic [10:0]        st_y_ff;
   logic [11:0]        st_xs_ff, st_xe_ff;
   span_type           span_ff;
   logic               span_valid_ff;

   function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
      if (v > 53'sh7FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (v < -(53'sh80000000)) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [12:0] rnd_coord(input logic signed [15:0] v);
      logic signed [16:0] t;
      t = 17'(v) + 17'(ONE_PX / 2);
      return 13'(t >>> COORD_FRAC_BITS);
   endfunction

   function automatic logic signed [16:0] rnd_q16(input logic signed [31:0] v);
      logic signed [32:0] t;
      t = 33'(v) + 33'sd32768;
      return 17'(t >>> 16);
   endfunction

   function automatic logic [11:0] clamp_x(input logic signed [16:0] v,
                                           input logic [11:0] w);
      if (v < 0) begin
         return 12'd0;
      end else if (v > $signed({5'b0, w})) begin
         return w;
      end
      return v[11:0];
   endfunction

   function automatic logic signed [DIV_W-1:0] shl16(input logic signed [16:0] d);
      return $signed({{(DIV_W-33){d[16]}}, d, 16'b0});
   endfunction

   function automatic logic signed [31:0] to_q16(input logic signed [15:0] v);
      return 32'(v) <<< Q16_SHIFT;
   endfunction

   // vertex sort of the queue head
   req_item_type       it;
   logic signed [15:0] s_lo_x, s_lo_y, s_md_x, s_md_y, s_hi_x, s_hi_y;
   logic signed [15:0] a_lo_x, a_lo_y, a_hi_x, a_hi_y;
   logic signed [16:0] s_dx, s_dy;
   logic               is_load;

   assign it      = head.item;
   assign is_load = (it.cmd == CMD_LOAD);

   always_comb begin
      if (it.v0_y > it.v1_y) begin
         a_lo_x = it.v1_x; a_lo_y = it.v1_y; a_hi_x = it.v0_x; a_hi_y = it.v0_y;
      end else begin
         a_lo_x = it.v0_x; a_lo_y = it.v0_y; a_hi_x = it.v1_x; a_hi_y = it.v1_y;
      end
      s_lo_x = a_lo_x; s_lo_y = a_lo_y; s_hi_x = a_hi_x; s_hi_y = a_hi_y;
      s_md_x = it.v2_x; s_md_y = it.v2_y;
      if (it.v2_y > a_hi_y) begin
         s_md_x = a_hi_x; s_md_y = a_hi_y; s_hi_x = it.v2_x; s_hi_y = it.v2_y;
      end else if (it.v2_y < a_lo_y) begin
         s_md_x = a_lo_x; s_md_y = a_lo_y; s_lo_x = it.v2_x; s_lo_y = it.v2_y;
      end
      s_dx = 17'(s_hi_x) - 17'(s_lo_x);
      s_dy = 17'(s_hi_y) - 17'(s_lo_y);
   end

   // edge deltas of the stored triangle
   logic signed [16:0] d_dx, d_dy, d_bx, d_by, d_tx, d_ty;

   assign d_dx = 17'(mxx_ff) - 17'(mnx_ff);
   assign d_dy = 17'(mxy_ff) - 17'(mny_ff);
   assign d_bx = 17'(mdx_ff) - 17'(mnx_ff);
   assign d_by = 17'(mdy_ff) - 17'(mny_ff);
   assign d_tx = 17'(mxx_ff) - 17'(mdx_ff);
   assign d_ty = 17'(mxy_ff) - 17'(mdy_ff);

   // span step
   logic signed [31:0] lslope, rslope, left_adv, right_adv, mq, px;
   logic [11:0]        row_nx;
   logic               half_done;
   logic               tick_live;

   assign lslope    = long_right_ff ? short_slope_ff : long_slope_ff;
   assign rslope    = long_right_ff ? long_slope_ff : short_slope_ff;
   assign left_adv  = sat32(53'(left_ff) + 53'(lslope));
   assign right_adv = sat32(53'(right_ff) + 53'(rslope));
   assign row_nx    = cur_row_ff + 12'd1;
   assign half_done = (row_nx >= end_row_ff);
   assign tick_live = (phase_ff != PH_IDLE);
   assign mq        = to_q16(mdx_ff);
   assign px        = sat32(53'(to_q16(mnx_ff)) + 53'(div_rsp.quot));

   // row range of the pending half, clipped to the screen
   logic signed [12:0] ys, ye;
   logic signed [13:0] ys_c, ye_c, h14, ys_neg;
   logic [11:0]        skip_c;
   logic               rows_ok;

   always_comb begin
      ys     = half_up_ff ? rnd_coord(mdy_ff) : rnd_coord(mny_ff);
      ye     = half_up_ff ? rnd_coord(mxy_ff) : rnd_coord(mdy_ff);
      h14    = $signed({2'b00, lim.height});
      ys_neg = 14'sd0 - 14'(ys);
      ys_c   = (ys < 0) ? 14'sd0 : 14'(ys);
      skip_c = (ys < 0) ? ys_neg[11:0] : 12'd0;
      ye_c   = (14'(ye) > h14) ? h14 : 14'(ye);
      rows_ok = (ys_c < ye_c);
   end

   state_type fin;
   assign fin = from_tick_ff ? ST_EMIT : ST_FETCH;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FETCH: begin
            if (head.valid) begin
               if (is_load) begin
                  state_in = (s_dy < ONE_PX) ? ST_FETCH : ST_LDIV;
               end else if (tick_live) begin
                  state_in = (half_done && phase_ff == PH_LOWER) ? ST_UP_CHK : ST_EMIT;
               end
            end
         end
         ST_LDIV:    if (div_rsp.done) state_in = ST_LO_CHK;
         ST_LO_CHK:  state_in = (d_by > ONE_PX) ? ST_LO_DIV : ST_UP_CHK;
         ST_LO_DIV:  if (div_rsp.done) state_in = ST_LO_M1;
         ST_LO_M1:   state_in = ST_LO_M2;
         ST_LO_M2:   state_in = ST_LO_CMP;
         ST_LO_CMP:  state_in = ST_ROWS;
         ST_UP_CHK:  state_in = (d_ty > ONE_PX) ? ST_UP_DIV : fin;
         ST_UP_DIV:  if (div_rsp.done) state_in = ST_UP_M1;
         ST_UP_M1:   state_in = ST_UP_M2;
         ST_UP_M2:   state_in = ST_UP_M3;
         ST_UP_M3:   state_in = ST_UP_M4;
         ST_UP_M4:   state_in = ST_UP_PDIV;
         ST_UP_PDIV: if (div_rsp.done) state_in = ST_ROWS;
         ST_ROWS: begin
            if (rows_ok) begin
               state_in = ST_SK1;
            end else begin
               state_in = half_up_ff ? fin : ST_UP_CHK;
            end
         end
         ST_SK1:     state_in = ST_SK2;
         ST_SK2:     state_in = ST_SK3;
         ST_SK3:     state_in = fin;
         ST_EMIT:    if (!span_valid_ff || span_ready) state_in = ST_FETCH;
         default:    state_in = ST_FETCH;
      endcase
   end

   // state outputs: queue pop, multiplier operands, divider requests
   always_comb begin
      head_pop      = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      div_req.start = 1'b0;
      div_req.numer = '0;
      div_req.denom = '0;
      case (state_ff)
         ST_FETCH: begin
            head_pop = head.valid;
            if (head.valid && is_load && s_dy >= ONE_PX) begin
               div_req.start = 1'b1;
               div_req.numer = shl16(s_dx);
               div_req.denom = s_dy;
            end
         end
         ST_LO_CHK: begin
            if (d_by > ONE_PX) begin
               div_req.start = 1'b1;
               div_req.numer = shl16(d_bx);
               div_req.denom = d_by;
            end
         end
         ST_UP_CHK: begin
            if (d_ty > ONE_PX) begin
               div_req.start = 1'b1;
               div_req.numer = shl16(d_tx);
               div_req.denom = d_ty;
            end
         end
         ST_LO_M1: begin mul_a = 33'(d_dx); mul_b = 18'(d_by); end
         ST_LO_M2: begin mul_a = 33'(d_bx); mul_b = 18'(d_dy); end
         ST_UP_M1: begin mul_a = 33'(d_tx); mul_b = 18'(d_dy); end
         ST_UP_M2: begin mul_a = 33'(d_dx); mul_b = 18'(d_ty); end
         ST_UP_M3: begin mul_a = 33'(d_dx); mul_b = 18'(d_by); end
         ST_UP_M4: begin
            div_req.start = 1'b1;
            div_req.numer = $signed(DIV_W'(prod_ff)) <<< Q16_SHIFT;
            div_req.denom = d_dy;
         end
         ST_SK1: begin mul_a = 33'(lslope); mul_b = $signed({6'b0, skip_ff}); end
         ST_SK2: begin mul_a = 33'(rslope); mul_b = $signed({6'b0, skip_ff}); end
         default: begin
         end
      endcase
   end

   // shared multiplier, registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FETCH;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         half_up_ff   <= 1'b0;
         from_tick_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_FETCH: begin
               if (head.valid) begin
                  if (is_load) begin
                     phase_ff     <= PH_IDLE;
                     from_tick_ff <= 1'b0;
                  end else if (tick_live && half_done) begin
                     if (phase_ff == PH_LOWER) begin
                        from_tick_ff <= 1'b1;
                     end else begin
                        phase_ff <= PH_IDLE;
                     end
                  end
               end
            end
            ST_LO_CMP: half_up_ff <= 1'b0;
            ST_UP_CHK: begin
               half_up_ff <= 1'b1;
               if (!(d_ty > ONE_PX)) begin
                  phase_ff <= PH_IDLE;
               end
            end
            ST_ROWS: begin
               if (rows_ok) begin
                  phase_ff <= half_up_ff ? PH_UPPER : PH_LOWER;
               end else if (half_up_ff) begin
                  phase_ff <= PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // triangle and edge datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_FETCH: begin
            if (head.valid) begin
               if (is_load) begin
                  mnx_ff   <= s_lo_x; mny_ff <= s_lo_y;
                  mdx_ff   <= s_md_x; mdy_ff <= s_md_y;
                  mxx_ff   <= s_hi_x; mxy_ff <= s_hi_y;
                  color_ff <= it.color;
               end else if (tick_live) begin
                  st_y_ff    <= cur_row_ff[10:0];
                  st_xs_ff   <= clamp_x(rnd_q16(left_ff), lim.width);
                  st_xe_ff   <= clamp_x(rnd_q16(right_ff), lim.width);
                  left_ff    <= left_adv;
                  right_ff   <= right_adv;
                  cur_row_ff <= row_nx;
               end
            end
         end
         ST_LDIV:   if (div_rsp.done) long_slope_ff <= sat32(53'(div_rsp.quot));
         ST_LO_DIV: if (div_rsp.done) short_slope_ff <= sat32(53'(div_rsp.quot));
         ST_UP_DIV: if (div_rsp.done) short_slope_ff <= sat32(53'(div_rsp.quot));
         ST_LO_M2:  p1_ff <= prod_ff;
         ST_UP_M2:  p1_ff <= prod_ff;
         ST_LO_CMP: begin
            long_right_ff <= (p1_ff > prod_ff);
            left_ff       <= to_q16(mnx_ff);
            right_ff      <= to_q16(mnx_ff);
         end
         ST_UP_M3:  long_right_ff <= (p1_ff > prod_ff);
         ST_UP_PDIV: begin
            if (div_rsp.done) begin
               left_ff  <= long_right_ff ? mq : px;
               right_ff <= long_right_ff ? px : mq;
            end
         end
         ST_ROWS: begin
            if (rows_ok) begin
               cur_row_ff <= ys_c[11:0];
               end_row_ff <= ye_c[11:0];
               skip_ff    <= skip_c;
            end
         end
         ST_SK2: left_ff  <= sat32(53'(left_ff) + 53'(prod_ff));
         ST_SK3: right_ff <= sat32(53'(right_ff) + 53'(prod_ff));
         default: begin
         end
      endcase
   end

   // output register
   logic emit_load;
   assign emit_load = (state_ff == ST_EMIT) && (!span_valid_ff || span_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         span_valid_ff <= 1'b0;
      end else if (emit_load) begin
         span_valid_ff <= 1'b1;
      end else if (span_ready) begin
         span_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         span_ff.y       <= st_y_ff;
         span_ff.x_start <= st_xs_ff;
         span_ff.x_end   <= st_xe_ff;
         span_ff.color   <= color_ff;
         span_ff.empty   <= (st_xs_ff >= st_xe_ff);
         span_ff.last    <= (phase_ff == PH_IDLE);
      end
   end

   assign span_valid = span_valid_ff;
   assign span       = span_ff;

   // a new span only ever comes out of the emit state
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(span_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("span loaded outside emit state");

   // an active half always has a row left when the next item is fetched
   a_row_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH && phase_ff != PH_IDLE) |-> cur_row_ff < end_row_ff)
      else $error("active half without rows");

   // divider results arrive only while the sequencer waits for them
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_LDIV || state_ff == ST_LO_DIV ||
                        state_ff == ST_UP_DIV || state_ff == ST_UP_PDIV))
      else $error("divider done outside a wait state");

endmodule

>>> rtl/core/flat_triangle_scanline_raster_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata vertices and color, tuser command
// rsp      out  rsp_tvalid/rsp_tready  tdata span, tuser empty, tlast last span
// csr      in   APB psel/penable       screen_width @0x0, screen_height @0x4
//
// While a half runs, a tick passes through the fetch state and the emit
// state, which loads the output register. A load runs one division of the
// serial divider for the long edge and one per half setup (the upper half
// needs two), plus multiply steps on the shared multiplier; a tick that
// ends the lower half also carries the upper half setup.
// A 4-entry command queue keeps accepting items while setup runs or a span
// waits in the output register. Synchronous reset; no clearing pass.
module flat_triangle_scanline_raster_unit import ftsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y (16 each), fill_color (32)
   input  logic [127:0]      req_tdata,
   // cmd
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // span_y (11), span_x_start (12), span_x_end (12), span_color (32), zero pad (5)
   output logic [71:0]       rsp_tdata,
   // span_empty
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [11:0]  width_ff, height_ff;
   logic         csr_wr;
   limit_type    lim;
   req_item_type in_item;
   q_head_type   head;
   logic         head_pop;
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   span_type     span;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 12'd480;
      end else if (csr_wr) begin
         case (csr_paddr[CSR_AW-1])
            REG_SCREEN_WIDTH:  width_ff  <= csr_pwdata[11:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_AW-1])
         REG_SCREEN_WIDTH:  csr_prdata = {20'b0, width_ff};
         REG_SCREEN_HEIGHT: csr_prdata = {20'b0, height_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // effective clip limits
   assign lim.width  = (width_ff > 12'(MAX_SCREEN)) ? 12'(MAX_SCREEN) : width_ff;
   assign lim.height = (height_ff > 12'(MAX_SCREEN)) ? 12'(MAX_SCREEN) : height_ff;

   // input unpack
   assign in_item.cmd   = req_tuser;
   assign in_item.v0_x  = req_tdata[15:0];
   assign in_item.v0_y  = req_tdata[31:16];
   assign in_item.v1_x  = req_tdata[47:32];
   assign in_item.v1_y  = req_tdata[63:48];
   assign in_item.v2_x  = req_tdata[79:64];
   assign in_item.v2_y  = req_tdata[95:80];
   assign in_item.color = req_tdata[127:96];

   ftsr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_item  (in_item),
      .in_ready (req_tready),
      .head     (head),
      .pop      (head_pop)
   );

   ftsr_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ftsr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_pop   (head_pop),
      .lim        (lim),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .span_valid (rsp_tvalid),
      .span       (span),
      .span_ready (rsp_tready)
   );

   // output pack
   assign rsp_tdata = {5'b0, span.color, span.x_end, span.x_start, span.y};
   assign rsp_tuser = span.empty;
   assign rsp_tlast = span.last;

endmodule
